// File: sv/vrfla_pkg.sv
// Shared types, constants and helpers for the vertex range free list allocator.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
package vrfla_pkg;

   localparam int MAX_FREE_RANGES = 32;
   localparam int ADDRESS_SPACE   = 65536;
   localparam int LEN_W           = 17;
   localparam int START_W         = 16;
   localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FEW  = 2'd1;
   localparam logic [1:0] ST_FIT  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_INIT,
      CMD_LOAD,
      CMD_FAIL_FEW,
      CMD_FAIL_FIT,
      CMD_FAIL_FULL,
      CMD_READ_IDX,
      CMD_IDX_INC,
      CMD_A_CHECK,
      CMD_SET_K_BEST,
      CMD_READ_K1,
      CMD_WRITE_K,
      CMD_A_FINISH,
      CMD_S_BEGIN,
      CMD_S_LOAD0,
      CMD_S_TAIL,
      CMD_S_COMPARE,
      CMD_M_INIT,
      CMD_M_CHECK,
      CMD_M_SHEND,
      CMD_R_FINISH,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic op;
      logic too_few;
      logic idx_end;
      logic k_end;
      logic found;
      logic full;
      logic small_table;
      logic swapped;
      logic exact;
      logic adj;
      logic out_free;
   } stat_type;

   function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
   endfunction

endpackage

// File: sv/vrfla_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vrfla_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/vrfla_ctrl.sv
// Sequencer of the free list allocator: steps allocate scans, release sort and merge.
// Depends on vrfla_pkg; drives commands into vrfla_dp and reads its status.
`timescale 1ns / 1ps
module vrfla_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vrfla_pkg::stat_type stat,
   output vrfla_pkg::cmd_type  cmd
);

   typedef enum logic [21:0] {
      S_INIT   = 22'h000001,
      S_IDLE   = 22'h000002,
      S_DISP   = 22'h000004,
      S_A_RD   = 22'h000008,
      S_A_CHK  = 22'h000010,
      S_A_END  = 22'h000020,
      S_A_SHRD = 22'h000040,
      S_A_SHWR = 22'h000080,
      S_A_FIN  = 22'h000100,
      S_P_RD   = 22'h000200,
      S_P_CHK  = 22'h000400,
      S_S_BEG  = 22'h000800,
      S_S_LD0  = 22'h001000,
      S_S_RD   = 22'h002000,
      S_S_CMP  = 22'h004000,
      S_M_RD   = 22'h008000,
      S_M_CHK  = 22'h010000,
      S_M_SHRD = 22'h020000,
      S_M_SHWR = 22'h040000,
      S_M_SHND = 22'h080000,
      S_R_FIN  = 22'h100000,
      S_DONE   = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = vrfla_pkg::CMD_NOP;
      case (state_ff)
         S_INIT: begin
            cmd      = vrfla_pkg::CMD_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = vrfla_pkg::CMD_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.op == vrfla_pkg::OP_ALLOC) begin
               if (stat.too_few) begin
                  cmd      = vrfla_pkg::CMD_FAIL_FEW;
                  state_in = S_DONE;
               end else begin
                  state_in = S_A_RD;
               end
            end else begin
               state_in = stat.full ? S_P_RD : S_S_BEG;
            end
         end
         S_A_RD: begin
            if (stat.idx_end) begin
               state_in = S_A_END;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_IDX;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            cmd      = vrfla_pkg::CMD_A_CHECK;
            state_in = stat.exact ? S_A_END : S_A_RD;
         end
         S_A_END: begin
            if (stat.found) begin
               cmd      = vrfla_pkg::CMD_SET_K_BEST;
               state_in = S_A_SHRD;
            end else begin
               cmd      = vrfla_pkg::CMD_FAIL_FIT;
               state_in = S_DONE;
            end
         end
         S_A_SHRD: begin
            if (stat.k_end) begin
               state_in = S_A_FIN;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_K1;
               state_in = S_A_SHWR;
            end
         end
         S_A_SHWR: begin
            cmd      = vrfla_pkg::CMD_WRITE_K;
            state_in = S_A_SHRD;
         end
         S_A_FIN: begin
            cmd      = vrfla_pkg::CMD_A_FINISH;
            state_in = S_DONE;
         end
         S_P_RD: begin
            if (stat.idx_end) begin
               cmd      = vrfla_pkg::CMD_FAIL_FULL;
               state_in = S_DONE;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_IDX;
               state_in = S_P_CHK;
            end
         end
         S_P_CHK: begin
            if (stat.adj) begin
               state_in = S_S_BEG;
            end else begin
               cmd      = vrfla_pkg::CMD_IDX_INC;
               state_in = S_P_RD;
            end
         end
         S_S_BEG: begin
            if (stat.small_table) begin
               cmd      = vrfla_pkg::CMD_M_INIT;
               state_in = S_M_RD;
            end else begin
               cmd      = vrfla_pkg::CMD_S_BEGIN;
               state_in = S_S_LD0;
            end
         end
         S_S_LD0: begin
            cmd      = vrfla_pkg::CMD_S_LOAD0;
            state_in = S_S_RD;
         end
         S_S_RD: begin
            if (stat.idx_end) begin
               cmd      = vrfla_pkg::CMD_S_TAIL;
               state_in = stat.swapped ? S_S_BEG : S_M_RD;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_IDX;
               state_in = S_S_CMP;
            end
         end
         S_S_CMP: begin
            cmd      = vrfla_pkg::CMD_S_COMPARE;
            state_in = S_S_RD;
         end
         S_M_RD: begin
            if (stat.idx_end) begin
               state_in = S_R_FIN;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_IDX;
               state_in = S_M_CHK;
            end
         end
         S_M_CHK: begin
            cmd      = vrfla_pkg::CMD_M_CHECK;
            state_in = stat.adj ? S_M_SHRD : S_M_RD;
         end
         S_M_SHRD: begin
            if (stat.k_end) begin
               state_in = S_M_SHND;
            end else begin
               cmd      = vrfla_pkg::CMD_READ_K1;
               state_in = S_M_SHWR;
            end
         end
         S_M_SHWR: begin
            cmd      = vrfla_pkg::CMD_WRITE_K;
            state_in = S_M_SHRD;
         end
         S_M_SHND: begin
            cmd      = vrfla_pkg::CMD_M_SHEND;
            state_in = S_M_RD;
         end
         S_R_FIN: begin
            cmd      = vrfla_pkg::CMD_R_FINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd      = vrfla_pkg::CMD_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: sv/vrfla_dp.sv
// Datapath of the free list allocator: free table RAM, counters, totals, result register.
// Depends on vrfla_pkg and vrfla_ram; executes commands from vrfla_ctrl.
`timescale 1ns / 1ps
module vrfla_dp #(
   parameter int MAX_FREE_RANGES = vrfla_pkg::MAX_FREE_RANGES,
   parameter int ADDRESS_SPACE   = vrfla_pkg::ADDRESS_SPACE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vrfla_pkg::cmd_type        cmd,
   output vrfla_pkg::stat_type       stat,
   input  logic                      req_op,
   input  logic [16:0]               req_vertex_count,
   input  logic [15:0]               req_start_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_granted,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_chunk_start,
   output logic [16:0]               rsp_free_vertices,
   input  logic                      cfg_wr,
   input  logic [16:0]               cfg_data,
   output logic [16:0]               capacity
);

   localparam int IW = $clog2(MAX_FREE_RANGES);
   localparam int CW = $clog2(MAX_FREE_RANGES + 1);
   localparam int DW = vrfla_pkg::START_W + vrfla_pkg::LEN_W;
   localparam logic [16:0] AS_LEN = 17'(ADDRESS_SPACE);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_RANGES);

   logic [16:0]   cap_ff, cap_in;
   logic [CW-1:0] used_ff, used_in;
   logic [16:0]   free_ff, free_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] best_ff, best_in;
   logic          op_ff, op_in;
   logic [16:0]   n_ff, n_in;
   logic [15:0]   cs_ff, cs_in;
   logic [16:0]   cc_ff, cc_in;
   logic          found_ff, found_in;
   logic [15:0]   best_start_ff, best_start_in;
   logic [16:0]   best_len_ff, best_len_in;
   logic          swapped_ff, swapped_in;
   logic [15:0]   carry_start_ff, carry_start_in;
   logic [16:0]   carry_len_ff, carry_len_in;
   logic          res_granted_ff, res_granted_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_start_ff, res_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_granted_ff, rsp_granted_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_start_ff, rsp_start_in;
   logic [16:0]   rsp_free_ff, rsp_free_in;

   logic          we;
   logic [IW-1:0] waddr, raddr;
   logic [DW-1:0] wdata, rdata;
   logic [15:0]   rd_start;
   logic [16:0]   rd_len;
   logic [17:0]   req_end, ent_end;
   logic          adj;
   logic [CW:0]   k_next;
   logic [16:0]   cap_val;
   logic [CW-1:0] used_m1;

   vrfla_ram #(.WIDTH(DW), .DEPTH(MAX_FREE_RANGES)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rd_start = rdata[DW-1 -: 16];
   assign rd_len   = rdata[16:0];
   assign req_end  = {2'b00, cs_ff} + {1'b0, cc_ff};
   assign ent_end  = {2'b00, rd_start} + {1'b0, rd_len};
   assign adj      = ({2'b00, rd_start} == req_end) || (ent_end == {2'b00, cs_ff});
   assign k_next   = {1'b0, k_ff} + {{CW{1'b0}}, 1'b1};
   assign used_m1  = used_ff - CW'(1);

   always_comb begin
      cap_val = cfg_data;
      if (cap_val == 17'd0) begin
         cap_val = 17'd1;
      end else if (cap_val > AS_LEN) begin
         cap_val = AS_LEN;
      end
   end

   always_comb begin
      case (cmd)
         vrfla_pkg::CMD_READ_K1: raddr = k_next[IW-1:0];
         vrfla_pkg::CMD_S_BEGIN: raddr = '0;
         default:                raddr = idx_ff[IW-1:0];
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = {16'd0, cap_ff};
      if (cfg_wr) begin
         we    = 1'b1;
         wdata = {16'd0, cap_val};
      end else begin
         case (cmd)
            vrfla_pkg::CMD_INIT: begin
               we = 1'b1;
            end
            vrfla_pkg::CMD_WRITE_K: begin
               we    = 1'b1;
               waddr = k_ff[IW-1:0];
               wdata = rdata;
            end
            vrfla_pkg::CMD_A_FINISH: begin
               we    = (best_len_ff > n_ff);
               waddr = used_m1[IW-1:0];
               wdata = {best_start_ff + n_ff[15:0], best_len_ff - n_ff};
            end
            vrfla_pkg::CMD_S_TAIL: begin
               we    = 1'b1;
               waddr = used_m1[IW-1:0];
               wdata = {carry_start_ff, carry_len_ff};
            end
            vrfla_pkg::CMD_S_COMPARE: begin
               we    = 1'b1;
               waddr = idx_ff[IW-1:0] - IW'(1);
               wdata = (carry_start_ff > rd_start) ? rdata : {carry_start_ff, carry_len_ff};
            end
            vrfla_pkg::CMD_R_FINISH: begin
               we    = 1'b1;
               waddr = used_ff[IW-1:0];
               wdata = {cs_ff, cc_ff};
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cap_in         = cap_ff;
      used_in        = used_ff;
      free_in        = free_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      best_in        = best_ff;
      op_in          = op_ff;
      n_in           = n_ff;
      cs_in          = cs_ff;
      cc_in          = cc_ff;
      found_in       = found_ff;
      best_start_in  = best_start_ff;
      best_len_in    = best_len_ff;
      swapped_in     = swapped_ff;
      carry_start_in = carry_start_ff;
      carry_len_in   = carry_len_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (cmd)
         vrfla_pkg::CMD_INIT: begin
            used_in = CW'(1);
            free_in = cap_ff;
         end
         vrfla_pkg::CMD_LOAD: begin
            op_in    = req_op;
            n_in     = req_vertex_count;
            cs_in    = req_start_index;
            cc_in    = req_vertex_count;
            idx_in   = '0;
            found_in = 1'b0;
         end
         vrfla_pkg::CMD_FAIL_FEW, vrfla_pkg::CMD_FAIL_FIT, vrfla_pkg::CMD_FAIL_FULL: begin
            res_granted_in = 1'b0;
            res_start_in   = '0;
            case (cmd)
               vrfla_pkg::CMD_FAIL_FEW: res_status_in = vrfla_pkg::ST_FEW;
               vrfla_pkg::CMD_FAIL_FIT: res_status_in = vrfla_pkg::ST_FIT;
               default:                 res_status_in = vrfla_pkg::ST_FULL;
            endcase
         end
         vrfla_pkg::CMD_IDX_INC: begin
            idx_in = idx_ff + CW'(1);
         end
         vrfla_pkg::CMD_A_CHECK: begin
            if ((rd_len == n_ff) ||
                ((n_ff < rd_len) && (!found_ff || (best_len_ff < rd_len)))) begin
               best_in       = idx_ff;
               best_start_in = rd_start;
               best_len_in   = rd_len;
               found_in      = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         vrfla_pkg::CMD_SET_K_BEST: begin
            k_in = best_ff;
         end
         vrfla_pkg::CMD_WRITE_K: begin
            k_in = k_next[CW-1:0];
         end
         vrfla_pkg::CMD_A_FINISH: begin
            free_in        = free_ff - n_ff;
            used_in        = (best_len_ff > n_ff) ? used_ff : used_m1;
            res_granted_in = 1'b1;
            res_status_in  = vrfla_pkg::ST_OK;
            res_start_in   = best_start_ff;
         end
         vrfla_pkg::CMD_S_BEGIN: begin
            swapped_in = 1'b0;
         end
         vrfla_pkg::CMD_S_LOAD0: begin
            carry_start_in = rd_start;
            carry_len_in   = rd_len;
            idx_in         = CW'(1);
         end
         vrfla_pkg::CMD_S_TAIL, vrfla_pkg::CMD_M_INIT: begin
            idx_in = '0;
         end
         vrfla_pkg::CMD_S_COMPARE: begin
            if (carry_start_ff > rd_start) begin
               swapped_in = 1'b1;
            end else begin
               carry_start_in = rd_start;
               carry_len_in   = rd_len;
            end
            idx_in = idx_ff + CW'(1);
         end
         vrfla_pkg::CMD_M_CHECK: begin
            if (adj) begin
               cs_in = (rd_start < cs_ff) ? rd_start : cs_ff;
               cc_in = vrfla_pkg::sat_add(cc_ff, rd_len);
               k_in  = idx_ff;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         vrfla_pkg::CMD_M_SHEND: begin
            used_in = used_m1;
            idx_in  = (idx_ff != '0) ? (idx_ff - CW'(1)) : '0;
         end
         vrfla_pkg::CMD_R_FINISH: begin
            used_in        = used_ff + CW'(1);
            free_in        = vrfla_pkg::sat_add(free_ff, n_ff);
            res_granted_in = 1'b1;
            res_status_in  = vrfla_pkg::ST_OK;
            res_start_in   = '0;
         end
         vrfla_pkg::CMD_EMIT: begin
            rsp_valid_in   = 1'b1;
            rsp_granted_in = res_granted_ff;
            rsp_status_in  = res_status_ff;
            rsp_start_in   = res_start_ff;
            rsp_free_in    = free_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
      if (cfg_wr) begin
         cap_in  = cap_val;
         used_in = CW'(1);
         free_in = cap_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= AS_LEN;
         used_ff      <= CW'(1);
         free_ff      <= AS_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      k_ff           <= k_in;
      best_ff        <= best_in;
      op_ff          <= op_in;
      n_ff           <= n_in;
      cs_ff          <= cs_in;
      cc_ff          <= cc_in;
      found_ff       <= found_in;
      best_start_ff  <= best_start_in;
      best_len_ff    <= best_len_in;
      swapped_ff     <= swapped_in;
      carry_start_ff <= carry_start_in;
      carry_len_ff   <= carry_len_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      res_start_ff   <= res_start_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_free_ff    <= rsp_free_in;
   end

   always_comb begin
      stat.op          = op_ff;
      stat.too_few     = (n_ff > free_ff);
      stat.idx_end     = (idx_ff >= used_ff);
      stat.k_end       = (k_next >= {1'b0, used_ff});
      stat.found       = found_ff;
      stat.full        = (used_ff == MAX_CNT);
      stat.small_table = (used_ff < CW'(2));
      stat.swapped     = swapped_ff;
      stat.exact       = (rd_len == n_ff);
      stat.adj         = adj;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chunk_start   = rsp_start_ff;
   assign rsp_free_vertices = rsp_free_ff;
   assign capacity          = cap_ff;

`ifndef ASSERT_OFF
   a_finish_has_range: assert property (@(posedge clock) disable iff (reset)
      (cmd == vrfla_pkg::CMD_A_FINISH) |-> found_ff)
      else $error("allocate finished without a chosen range");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd == vrfla_pkg::CMD_EMIT) |=> rsp_valid_ff)
      else $error("result register not loaded");

   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && (cmd != vrfla_pkg::CMD_EMIT)) |=> !rsp_valid_ff)
      else $error("result item repeated after it was taken");
`endif

endmodule

// File: sv/vertex_range_free_list_allocator.sv
// Vertex range free list allocator: first exact fit or first largest fit, release with
// sort and merge. The shortest item is an allocate refused for too few vertices; an
// allocate scans the table and shifts it, and a release (after an adjacency scan when the
// table is full) runs a stable bubble sort of the ranges in use and then merges adjacent
// ranges, each step reading the free table RAM (one write port, one read port). After
// reset the initial range is written before the first item is taken.
// Depends on vrfla_pkg, vrfla_ctrl, vrfla_dp and vrfla_ram.
`timescale 1ns / 1ps
module vertex_range_free_list_allocator #(
   parameter int MAX_FREE_RANGES = vrfla_pkg::MAX_FREE_RANGES,
   parameter int ADDRESS_SPACE   = vrfla_pkg::ADDRESS_SPACE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [16:0] req_vertex_count,
   input  logic [15:0] req_start_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_chunk_start,
   output logic [16:0] rsp_free_vertices,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   vrfla_pkg::cmd_type  cmd;
   vrfla_pkg::stat_type stat;
   logic                cfg_wr;
   logic [16:0]         capacity;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == vrfla_pkg::REG_CAPACITY);
   assign prdata = (paddr[2] == vrfla_pkg::REG_CAPACITY) ? {15'd0, capacity} : 32'd0;

   vrfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vrfla_dp #(
      .MAX_FREE_RANGES (MAX_FREE_RANGES),
      .ADDRESS_SPACE   (ADDRESS_SPACE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_vertex_count  (req_vertex_count),
      .req_start_index   (req_start_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted       (rsp_granted),
      .rsp_status        (rsp_status),
      .rsp_chunk_start   (rsp_chunk_start),
      .rsp_free_vertices (rsp_free_vertices),
      .cfg_wr            (cfg_wr),
      .cfg_data          (pwdata[16:0]),
      .capacity          (capacity)
   );

endmodule

// File: test/tb_vertex_range_free_list_allocator.sv
// Self-checking bench for the vertex range free list allocator: directed tests, table-full
// and back-pressure cases, then random allocate/release traffic over several capacities.
// Depends on vrfla_pkg and vertex_range_free_list_allocator.
`timescale 1ns / 1ps
module tb_vertex_range_free_list_allocator;

   typedef struct packed {
      logic        granted;
      logic [1:0]  status;
      logic [15:0] chunk_start;
      logic [16:0] free_vertices;
   } grant_type;

   typedef struct {
      int unsigned base;
      int unsigned cnt;
   } chunk_type;

   localparam int IDLE_LIMIT = 20000;
   localparam int BP_HOLD    = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = vrfla_pkg::OP_ALLOC;
   logic [16:0] req_vertex_count = '0;
   logic [15:0] req_start_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_granted;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_chunk_start;
   logic [16:0] rsp_free_vertices;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   vertex_range_free_list_allocator u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // allocator mirror
   int unsigned cap_model;
   int unsigned fr_start [vrfla_pkg::MAX_FREE_RANGES];
   int unsigned fr_len [vrfla_pkg::MAX_FREE_RANGES];
   int unsigned fr_used;
   int unsigned free_sum;

   grant_type   pending_grants [$];
   chunk_type   owned [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          grants_seen = 0;
   int          refusals [4] = '{0, 0, 0, 0};
   longint      cyc = 0;
   bit          bp_phase = 1'b0;
   int          bp_hold_cnt = 0;
   int          long_left = 0;
   int          quiet_cycles = 0;

   function automatic int unsigned len_sat(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > vrfla_pkg::LEN_MAX) ? vrfla_pkg::LEN_MAX : s;
   endfunction

   function automatic void table_init();
      foreach (fr_start[i]) begin
         fr_start[i] = 0;
         fr_len[i] = 0;
      end
      fr_len[0] = cap_model;
      fr_used = 1;
      free_sum = cap_model;
   endfunction

   function automatic grant_type mk(logic g, logic [1:0] st, int unsigned cs);
      grant_type r;
      r.granted = g;
      r.status = st;
      r.chunk_start = cs[15:0];
      r.free_vertices = free_sum[16:0];
      return r;
   endfunction

   function automatic grant_type carve(int unsigned n);
      int unsigned best, s, l;
      best = vrfla_pkg::MAX_FREE_RANGES;
      if (n > free_sum) return mk(1'b0, vrfla_pkg::ST_FEW, 0);
      for (int i = 0; i < fr_used; i++) begin
         if (fr_len[i] == n) begin
            best = i;
            break;
         end
         if (n < fr_len[i] && (best == vrfla_pkg::MAX_FREE_RANGES || fr_len[best] < fr_len[i]))
            best = i;
      end
      if (best == vrfla_pkg::MAX_FREE_RANGES) return mk(1'b0, vrfla_pkg::ST_FIT, 0);
      s = fr_start[best];
      l = fr_len[best];
      for (int i = best; i + 1 < fr_used; i++) begin
         fr_start[i] = fr_start[i+1];
         fr_len[i] = fr_len[i+1];
      end
      fr_used--;
      free_sum -= n;
      if (l > n && fr_used < vrfla_pkg::MAX_FREE_RANGES) begin
         fr_start[fr_used] = (s + n) & 16'hFFFF;
         fr_len[fr_used] = l - n;
         fr_used++;
      end
      return mk(1'b1, vrfla_pkg::ST_OK, s);
   endfunction

   function automatic grant_type give_back(int unsigned s, int unsigned c);
      int unsigned ts [vrfla_pkg::MAX_FREE_RANGES];
      int unsigned tl [vrfla_pkg::MAX_FREE_RANGES];
      int unsigned n, i, j, ks, kl, cs, cc;
      ts = fr_start;
      tl = fr_len;
      n = fr_used;
      cs = s;
      cc = c;
      for (i = 1; i < n; i++) begin
         ks = ts[i];
         kl = tl[i];
         j = i;
         while (j > 0 && ts[j-1] > ks) begin
            ts[j] = ts[j-1];
            tl[j] = tl[j-1];
            j--;
         end
         ts[j] = ks;
         tl[j] = kl;
      end
      i = 0;
      while (i < n) begin
         if (ts[i] == cs + cc || ts[i] + tl[i] == cs) begin
            if (ts[i] < cs) cs = ts[i];
            cc = len_sat(cc, tl[i]);
            for (int k = i; k + 1 < n; k++) begin
               ts[k] = ts[k+1];
               tl[k] = tl[k+1];
            end
            n--;
            if (i > 0) i--;
         end else begin
            i++;
         end
      end
      if (n >= vrfla_pkg::MAX_FREE_RANGES) return mk(1'b0, vrfla_pkg::ST_FULL, 0);
      ts[n] = cs & 16'hFFFF;
      tl[n] = cc;
      n++;
      fr_start = ts;
      fr_len = tl;
      fr_used = n;
      free_sum = len_sat(free_sum, c);
      return mk(1'b1, vrfla_pkg::ST_OK, 0);
   endfunction

   task automatic set_capacity(int unsigned v);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cap_model = v & vrfla_pkg::LEN_MAX;
      if (cap_model == 0) cap_model = 1;
      if (cap_model > vrfla_pkg::ADDRESS_SPACE) cap_model = vrfla_pkg::ADDRESS_SPACE;
      table_init();
      owned.delete();
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (pending_grants.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   task automatic send_item(logic op, int unsigned cnt, int unsigned st, bit paced = 1);
      int gap;
      chunk_type ch;
      grant_type g;
      gap = paced ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_vertex_count <= cnt[16:0];
      req_start_index <= st[15:0];
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == vrfla_pkg::OP_ALLOC) begin
         g = carve(cnt & vrfla_pkg::LEN_MAX);
         if (g.granted && cnt > 0) begin
            ch.base = g.chunk_start;
            ch.cnt = cnt;
            owned.insert(owned.size(), ch);
         end
      end else begin
         g = give_back(st & 16'hFFFF, cnt & vrfla_pkg::LEN_MAX);
      end
      pending_grants.insert(pending_grants.size(), g);
   endtask

   // result checker
   always @(posedge clock) begin
      grant_type want;
      cyc <= cyc + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item at cycle %0d", cyc);
         end else begin
            want = pending_grants.pop_front();
            if (want.granted) grants_seen++;
            else refusals[want.status]++;
            if (rsp_granted !== want.granted || rsp_status !== want.status ||
                rsp_chunk_start !== want.chunk_start ||
                rsp_free_vertices !== want.free_vertices) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch cyc %0d: exp g=%0d s=%0d c=%0d f=%0d got g=%0d s=%0d c=%0d f=%0d",
                           cyc, want.granted, want.status, want.chunk_start,
                           want.free_vertices, rsp_granted, rsp_status, rsp_chunk_start,
                           rsp_free_vertices);
            end
         end
      end
   end

   // receiver stall: one long hold in the back-pressure test, random short and long gaps, periodic stall-free windows
   always @(posedge clock) begin
      int r;
      r = $urandom_range(99);
      if (bp_phase && bp_hold_cnt < BP_HOLD) begin
         rsp_stall <= 1'b1;
         bp_hold_cnt <= bp_hold_cnt + 1;
      end else if (long_left > 0) begin
         rsp_stall <= 1'b1;
         long_left <= long_left - 1;
      end else if ((cyc / 500) % 4 == 3) begin
         rsp_stall <= 1'b0;
      end else if (r == 0) begin
         rsp_stall <= 1'b1;
         long_left <= $urandom_range(60, 10);
      end else begin
         rsp_stall <= (r < 25);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb_vertex_range_free_list_allocator: errors");
         $finish;
      end
   end

   task automatic test_basic();
      set_capacity(65536);
      send_item(vrfla_pkg::OP_ALLOC, 0, 0);
      send_item(vrfla_pkg::OP_ALLOC, 100, 16'hFFFF);
      send_item(vrfla_pkg::OP_ALLOC, 131071, 0);
      send_item(vrfla_pkg::OP_ALLOC, 65536, 0);
      send_item(vrfla_pkg::OP_RELEASE, 100, 0);
      send_item(vrfla_pkg::OP_RELEASE, 0, 500);
      send_item(vrfla_pkg::OP_RELEASE, 50, 20);
      send_item(vrfla_pkg::OP_ALLOC, 0, 0);
      send_item(vrfla_pkg::OP_RELEASE, 131071, 16'hFFFF);
      send_item(vrfla_pkg::OP_ALLOC, 65536, 0);
      send_item(vrfla_pkg::OP_ALLOC, 131071, 0);
      settle();
      set_capacity(0);
      send_item(vrfla_pkg::OP_ALLOC, 1, 0);
      send_item(vrfla_pkg::OP_ALLOC, 0, 0);
      send_item(vrfla_pkg::OP_ALLOC, 1, 0);
      send_item(vrfla_pkg::OP_RELEASE, 1, 0);
      settle();
      set_capacity(32'h1FFFF);
      send_item(vrfla_pkg::OP_ALLOC, 65536, 0);
      send_item(vrfla_pkg::OP_ALLOC, 0, 0);
      settle();
   endtask

   task automatic test_table_full();
      set_capacity(64);
      for (int i = 0; i < 64; i++) send_item(vrfla_pkg::OP_ALLOC, 1, 0);
      for (int i = 0; i < 64; i += 2) send_item(vrfla_pkg::OP_RELEASE, 1, i);
      send_item(vrfla_pkg::OP_RELEASE, 1, 101);
      send_item(vrfla_pkg::OP_RELEASE, 1, 1);
      send_item(vrfla_pkg::OP_ALLOC, 3, 0);
      settle();
   endtask

   task automatic test_backpressure();
      set_capacity(4096);
      bp_phase = 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(vrfla_pkg::OP_ALLOC, $urandom_range(40, 1), 0, 0);
      settle();
      bp_phase = 1'b0;
   endtask

   task automatic test_random(int unsigned capv, int count);
      int r, k;
      chunk_type ch;
      int unsigned lim;
      set_capacity(capv);
      lim = (cap_model > 8) ? cap_model / 8 : 1;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45 || owned.size() == 0) begin
            k = $urandom_range(99);
            if (k < 80) send_item(vrfla_pkg::OP_ALLOC, $urandom_range(lim, 1), $urandom);
            else if (k < 88) send_item(vrfla_pkg::OP_ALLOC, 0, $urandom);
            else if (k < 95) send_item(vrfla_pkg::OP_ALLOC, $urandom_range(cap_model, 0), $urandom);
            else send_item(vrfla_pkg::OP_ALLOC, $urandom_range(131071, 0), $urandom);
         end else if (r < 87) begin
            k = $urandom_range(owned.size() - 1);
            ch = owned[k];
            owned.delete(k);
            send_item(vrfla_pkg::OP_RELEASE, ch.cnt, ch.base);
         end else begin
            send_item(vrfla_pkg::OP_RELEASE, $urandom_range(131071, 0), $urandom);
         end
      end
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      cap_model = vrfla_pkg::ADDRESS_SPACE;
      table_init();
      test_basic();
      test_table_full();
      test_backpressure();
      test_random(65536, 500);
      test_random(1, 150);
      test_random(37, 400);
      test_random(200, 500);
      test_random(4096, 450);
      $display("covered %0d items: %0d granted, refused few/fit/full %0d/%0d/%0d",
               items_sent, grants_seen, refusals[1], refusals[2], refusals[3]);
      if (mismatches == 0)
         $display("tb_vertex_range_free_list_allocator: clean");
      else
         $display("tb_vertex_range_free_list_allocator: errors");
      $finish;
   end

endmodule

// File: vertex_range_free_list_allocator.f
sv/vrfla_pkg.sv
sv/vrfla_ram.sv
sv/vrfla_ctrl.sv
sv/vrfla_dp.sv
sv/vertex_range_free_list_allocator.sv
test/tb_vertex_range_free_list_allocator.sv
